/* src/ipv4p_pkg.sv */
// shared types and constants for the ipv4 dotted address parser
`default_nettype none

package ipv4p_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned ADDR_W = 32;
    localparam int unsigned NUM_SAVED = 3;
    localparam int unsigned PCNT_W = 2;

    // parse phase codes
    localparam logic [1:0] PH_DONE  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_ZERO  = 2'd2;
    localparam logic [1:0] PH_PART  = 2'd3;

    // number base codes
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    // characters of interest
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_F_LO  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_F_UP  = 8'h46;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    localparam logic [PCNT_W-1:0] PCNT_MAX = 2'd3;

    // one finished string, produced in the cycle its last character is taken
    typedef struct packed {
        logic              fire;
        logic              valid_res;
        logic [ADDR_W-1:0] address;
    } ipv4p_res_t;

endpackage

`default_nettype wire

/* src/ipv4p_core.sv */
// per-character parse state and address assembly
`default_nettype none

module ipv4p_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          accept,
    input  wire logic                          start_of_string,
    input  wire logic [ipv4p_pkg::CHAR_W-1:0]  ch,
    output ipv4p_pkg::ipv4p_res_t              res
);
    import ipv4p_pkg::*;

    logic [1:0]        phase_reg, phase_next;
    logic [1:0]        base_reg, base_next;
    logic [ADDR_W-1:0] acc_reg, acc_next;
    logic [PCNT_W-1:0] pcnt_reg, pcnt_next;
    logic [ADDR_W-1:0] saved_reg [NUM_SAVED];

    logic              save_we;
    logic [PCNT_W-1:0] save_idx;

    logic [1:0]        ph;
    logic [PCNT_W-1:0] pc;
    logic [1:0]        eff_base;
    logic              run_part;
    logic              is_dec, is_hex_lo, is_hex_up, is_space, is_digit;
    logic [3:0]        digit;
    logic [ADDR_W-1:0] acc_mul;
    logic              range_err;
    logic [ADDR_W-1:0] addr_full;

    assign is_dec    = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_hex_lo = (ch >= CH_A_LO) && (ch <= CH_F_LO);
    assign is_hex_up = (ch >= CH_A_UP) && (ch <= CH_F_UP);
    assign is_space  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));

    // a start flag restarts the string whatever the old phase was
    assign ph       = start_of_string ? PH_START : phase_reg;
    assign pc       = start_of_string ? '0 : pcnt_reg;
    // the character after a leading zero is already read as octal
    assign eff_base = (ph == PH_ZERO) ? BASE_OCT : base_reg;

    // letters a-f sit at low nibble 1..6, so adding 9 gives 10..15
    assign digit = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);

    always_comb begin
        is_digit = is_dec || ((eff_base == BASE_HEX) && (is_hex_lo || is_hex_up));
        case (eff_base)
            BASE_HEX: acc_mul = {acc_reg[ADDR_W-5:0], 4'b0};
            BASE_OCT: acc_mul = {acc_reg[ADDR_W-4:0], 3'b0};
            default:  acc_mul = {acc_reg[ADDR_W-4:0], 3'b0} + {acc_reg[ADDR_W-2:0], 1'b0};
        endcase
    end

    // range of the last part depends on how many parts came before it
    always_comb begin
        unique case (pc)
            2'd0:    range_err = 1'b0;
            2'd1:    range_err = |acc_reg[31:24];
            2'd2:    range_err = |acc_reg[31:16];
            default: range_err = |acc_reg[31:8];
        endcase
        addr_full = acc_reg;
        if (pc >= 2'd1) addr_full = addr_full | {saved_reg[0][7:0], 24'b0};
        if (pc >= 2'd2) addr_full = addr_full | {saved_reg[1][15:0], 16'b0};
        if (pc >= 2'd3) addr_full = addr_full | {saved_reg[2][23:0], 8'b0};
    end

    always_comb begin
        phase_next = phase_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        pcnt_next  = pcnt_reg;
        save_we    = 1'b0;
        save_idx   = pc;
        run_part   = 1'b0;
        res        = '0;

        if (accept) begin
            pcnt_next = pc;
            phase_next = ph;
            unique case (ph)
                PH_START: begin
                    if (!is_dec) begin
                        res.fire   = 1'b1;
                        phase_next = PH_DONE;
                    end else if (ch == CH_ZERO) begin
                        acc_next   = '0;
                        phase_next = PH_ZERO;
                    end else begin
                        acc_next   = {{(ADDR_W-4){1'b0}}, ch[3:0]};
                        base_next  = BASE_DEC;
                        phase_next = PH_PART;
                    end
                end
                PH_ZERO: begin
                    phase_next = PH_PART;
                    if ((ch == CH_X_LO) || (ch == CH_X_UP)) begin
                        base_next = BASE_HEX;
                    end else begin
                        base_next = BASE_OCT;
                        run_part  = 1'b1;
                    end
                end
                PH_PART: run_part = 1'b1;
                default: ;
            endcase

            if (run_part) begin
                if (is_digit) begin
                    acc_next = acc_mul + {{(ADDR_W-4){1'b0}}, digit};
                end else if (ch == CH_DOT) begin
                    if (pc == PCNT_MAX) begin
                        res.fire   = 1'b1;
                        phase_next = PH_DONE;
                    end else begin
                        save_we    = 1'b1;
                        pcnt_next  = pc + 2'd1;
                        phase_next = PH_START;
                    end
                end else if ((ch == CH_NUL) || is_space) begin
                    res.fire      = 1'b1;
                    res.valid_res = !range_err;
                    res.address   = range_err ? '0 : addr_full;
                    phase_next    = PH_DONE;
                end else begin
                    res.fire   = 1'b1;
                    phase_next = PH_DONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DONE;
            base_reg  <= BASE_DEC;
            acc_reg   <= '0;
            pcnt_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            base_reg  <= base_next;
            acc_reg   <= acc_next;
            pcnt_reg  <= pcnt_next;
        end
    end

    // saved parts hold no reset, part count guards every read
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_SAVED; i++) begin
            if (save_we && (save_idx == PCNT_W'(i))) saved_reg[i] <= acc_reg;
        end
    end

endmodule

`default_nettype wire

/* src/ipv4_dotted_address_parser_top.sv */
// top level of the ipv4 dotted address parser with its result register
//
// channel  dir  tdata              tuser
// s_       in   [7:0] ch           [0] start_of_string
// m_       out  [31:0] address     [0] valid_res
//
// one character per cycle; a result appears the cycle after the character
// that ends the string (terminator, bad character or fourth dot).
// s_tready drops only while a result is held and m_tready is low.
// aresetn is synchronous; after reset characters are ignored until a start flag.
`default_nettype none

module ipv4_dotted_address_parser_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tuser,   // [0] start_of_string
    output wire logic        m_tvalid,
    input  wire logic        m_tready,
    output wire logic [31:0] m_tdata,   // [31:0] address
    output wire logic        m_tuser    // [0] valid_res
);
    import ipv4p_pkg::*;

    ipv4p_res_t        res;
    logic              accept;
    logic              m_valid_reg;
    logic              m_user_reg;
    logic [ADDR_W-1:0] m_data_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    ipv4p_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .start_of_string (s_tuser),
        .ch              (s_tdata),
        .res             (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && res.fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res.fire) begin
            m_user_reg <= res.valid_res;
            m_data_reg <= res.address;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

/* src/ipv4p_checker.sv */
// port-level checks for the ipv4 dotted address parser
`default_nettype none

module ipv4p_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a failed parse always reports address zero
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 32'd0)
        else $error("invalid result with nonzero address");

    // input side never stalls while the result slot is empty
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result slot");

    // a new result only follows an accepted character
    a_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result without an accepted request");

    // reset empties the result slot
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

endmodule

bind ipv4_dotted_address_parser_top ipv4p_checker u_ipv4p_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
